FILE: design/f32sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32sd_pkg
// Shared types and constants for the float32 shortest decimal digit block.
// ----------------------------------------------------------------------------
package f32sd_pkg;

  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_ZERO  = 2'd1;
  localparam logic [1:0] KIND_INF   = 2'd2;
  localparam logic [1:0] KIND_NAN   = 2'd3;

  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_BIAS_SH  = 8'd150;
  localparam logic [6:0] LOOP_BOUND   = 7'd64;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;
  localparam logic [3:0] DIGIT_NINE   = 4'd9;

  // Classified item handed from the front end to the digit engine
  typedef struct packed {
    logic [1:0]  kind;
    logic        neg;
    logic [22:0] frac;
    logic [7:0]  expo;
  } f32sd_item_t;

endpackage

FILE: design/f32sd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32sd_front
// Accept raw words and classify them as zero, infinity, NaN or finite.
// ----------------------------------------------------------------------------
module f32sd_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // float_bits [31:0]
  output logic                  q_valid,
  input  logic                  q_ready,
  output f32sd_pkg::f32sd_item_t q_item
);
  import f32sd_pkg::*;

  logic [7:0]  expo;
  logic [22:0] frac;

  assign expo = in_tdata[30:23];
  assign frac = in_tdata[22:0];

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;

  always_comb begin
    q_item.frac = frac;
    q_item.expo = expo;
    if (expo == 8'd0) begin
      q_item.kind = KIND_ZERO;
      q_item.neg  = 1'b0;
    end else if (expo == EXP_ALL_ONES) begin
      // drop the sign of a NaN
      q_item.kind = (frac == 23'd0) ? KIND_INF : KIND_NAN;
      q_item.neg  = (frac == 23'd0) ? in_tdata[31] : 1'b0;
    end else begin
      q_item.kind = KIND_DIGIT;
      q_item.neg  = in_tdata[31];
    end
  end

endmodule

FILE: design/f32sd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32sd_queue
// Two-entry queue between the classifier and the digit engine.
// ----------------------------------------------------------------------------
module f32sd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_valid,
  output logic                   wr_ready,
  input  f32sd_pkg::f32sd_item_t wr_item,
  output logic                   rd_valid,
  input  logic                   rd_ready,
  output f32sd_pkg::f32sd_item_t rd_item
);
  import f32sd_pkg::*;

  f32sd_item_t mem_r [2];
  logic        wptr_r;
  logic        rptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_item  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/f32sd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32sd_back
// Digit engine: exponent scaling, digit generation, rounding and emit.
// ----------------------------------------------------------------------------
module f32sd_back #(
  parameter int BIG_WORDS  = 5,
  parameter int MAX_DIGITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  f32sd_pkg::f32sd_item_t q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  import f32sd_pkg::*;

  localparam int W  = 32 * BIG_WORDS;
  localparam int NW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_L1A, ST_L1B, ST_UTA, ST_UTB,
    ST_DMUL, ST_DSUB, ST_LOAD, ST_EMIT, ST_SPEC
  } state_t;

  state_t         state_r;
  logic [W-1:0]   rem_r, scl_r, gbl_r, gab_r, tmp_r, dbl_r;
  logic [6:0]     cnt_r;
  logic [7:0]     exp_r;
  logic [NW-1:0]  n_r;
  logic [IW-1:0]  idx_r;
  logic [3:0]     d_r;
  logic           mode_r, rge_r, low_r, tie_r;
  logic [3:0]     digit_r [MAX_DIGITS];
  logic [23:0]    f_r;
  logic [7:0]     ex_r;
  logic           neg_r;

  logic           ov_r, ol_r;
  logic [1:0]     ok_r;
  logic           on_r;
  logic [3:0]     od_r;
  logic [6:0]     oe_r;

  logic [W-1:0]   rem10, gbl10, gab10, scl10, rem_dbl, s_minus_r;
  logic [W:0]     r_minus_s;
  logic [W-1:0]   f_ext;
  logic [7:0]     sh_up, sh_dn;
  logic [NW-1:0]  last_n;
  logic [IW-1:0]  last_idx;
  logic           ut_pos, ut_neg, high, inc;

  assign rem10     = (rem_r << 3) + (rem_r << 1);
  assign gbl10     = (gbl_r << 3) + (gbl_r << 1);
  assign gab10     = (gab_r << 3) + (gab_r << 1);
  assign scl10     = (scl_r << 3) + (scl_r << 1);
  assign rem_dbl   = {rem_r[W-2:0], 1'b0};
  assign s_minus_r = scl_r - rem_r;
  assign r_minus_s = {1'b0, rem_r} - {1'b0, scl_r};
  assign f_ext     = {{(W-24){1'b0}}, f_r};
  assign sh_up     = ex_r - EXP_BIAS_SH;
  assign sh_dn     = EXP_BIAS_SH - ex_r;
  assign last_n    = n_r - NW'(1);
  assign last_idx  = last_n[IW-1:0];

  assign ut_pos = rge_r || (gab_r > dbl_r);
  assign ut_neg = !rge_r && (gab_r < dbl_r);
  assign high   = ut_pos;
  assign inc    = (high && !low_r) || ((low_r == high) && tie_r);

  assign q_ready    = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {4'd0, oe_r, od_r, on_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      exp_r   <= '0;
      n_r     <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            f_r   <= {1'b1, q_item.frac};
            ex_r  <= q_item.expo;
            neg_r <= q_item.neg;
            if (q_item.kind == KIND_DIGIT) begin
              state_r <= ST_INIT;
            end else begin
              ov_r    <= 1'b1;
              ok_r    <= q_item.kind;
              on_r    <= q_item.neg;
              od_r    <= 4'd0;
              oe_r    <= 7'd0;
              ol_r    <= 1'b1;
              state_r <= ST_SPEC;
            end
          end
        end
        ST_SPEC: begin
          if (out_tready) begin
            ov_r    <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        ST_INIT: begin
          if (ex_r > EXP_BIAS_SH) begin
            rem_r <= f_ext << sh_up;
            scl_r <= W'(1);
            gbl_r <= W'(1) << sh_up;
            gab_r <= W'(1) << sh_up;
          end else begin
            rem_r <= f_ext;
            scl_r <= W'(1) << sh_dn;
            gbl_r <= W'(1);
            gab_r <= W'(1);
          end
          cnt_r   <= '0;
          exp_r   <= '0;
          state_r <= ST_L1A;
        end
        ST_L1A: begin
          if (cnt_r == LOOP_BOUND) begin
            cnt_r   <= '0;
            mode_r  <= 1'b0;
            state_r <= ST_UTA;
          end else begin
            tmp_r   <= rem10;
            state_r <= ST_L1B;
          end
        end
        ST_L1B: begin
          if (scl_r <= tmp_r) begin
            cnt_r   <= '0;
            mode_r  <= 1'b0;
            state_r <= ST_UTA;
          end else begin
            exp_r   <= exp_r - 8'd1;
            rem_r   <= tmp_r;
            gbl_r   <= gbl10;
            gab_r   <= gab10;
            cnt_r   <= cnt_r + 7'd1;
            state_r <= ST_L1A;
          end
        end
        ST_UTA: begin
          if (!mode_r && cnt_r == LOOP_BOUND) begin
            exp_r   <= exp_r - 8'd1;
            n_r     <= '0;
            state_r <= ST_DMUL;
          end else begin
            rge_r   <= (rem_r >= scl_r);
            dbl_r   <= {s_minus_r[W-2:0], 1'b0};
            low_r   <= (gbl_r > rem_dbl);
            tie_r   <= (scl_r < rem_dbl);
            state_r <= ST_UTB;
          end
        end
        ST_UTB: begin
          if (!mode_r) begin
            if (ut_neg) begin
              exp_r   <= exp_r - 8'd1;
              n_r     <= '0;
              state_r <= ST_DMUL;
            end else begin
              scl_r   <= scl10;
              exp_r   <= exp_r + 8'd1;
              cnt_r   <= cnt_r + 7'd1;
              state_r <= ST_UTA;
            end
          end else if (low_r || high || n_r == NW'(MAX_DIGITS)) begin
            // round the final digit
            if (inc) digit_r[last_idx] <= digit_r[last_idx] + 4'd1;
            idx_r   <= '0;
            state_r <= ST_LOAD;
          end else begin
            state_r <= ST_DMUL;
          end
        end
        ST_DMUL: begin
          rem_r   <= rem10;
          gbl_r   <= gbl10;
          gab_r   <= gab10;
          d_r     <= 4'd0;
          state_r <= ST_DSUB;
        end
        ST_DSUB: begin
          if (d_r < DIGIT_TEN && !r_minus_s[W]) begin
            rem_r <= r_minus_s[W-1:0];
            d_r   <= d_r + 4'd1;
          end else begin
            digit_r[n_r[IW-1:0]] <= d_r;
            n_r     <= n_r + NW'(1);
            mode_r  <= 1'b1;
            state_r <= ST_UTA;
          end
        end
        ST_LOAD: begin
          ov_r    <= 1'b1;
          ok_r    <= KIND_DIGIT;
          on_r    <= neg_r;
          od_r    <= (digit_r[idx_r] > DIGIT_NINE) ? DIGIT_NINE : digit_r[idx_r];
          oe_r    <= exp_r[6:0];
          ol_r    <= (idx_r == last_idx);
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_tready) begin
            ov_r <= 1'b0;
            if (ol_r) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + IW'(1);
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/float32_shortest_decimal_digits_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_shortest_decimal_digits_top
// Shortest decimal digit run of an IEEE single-precision word.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one raw float32 word per item. out_* returns one item per
//   decimal digit, most significant first, with tlast on the final digit.
//   Zero and denormal words give one zero-kind item, all-ones exponents give
//   one infinity or NaN item; kind travels in out_tuser.
// Processing:
//   The classifier passes items into a two-entry queue; the digit engine
//   takes one at a time. A finite word goes through two scaling passes
//   (each bounded at 64 iterations), then, per digit, a multiply step and
//   up to ten subtractions of the scale, then one emit per digit, all on
//   the 160-bit (default) add/compare paths of the engine. Special words go
//   straight to a single emit in the engine.
// Reset and stalls:
//   A synchronous active-low reset empties the queue and idles the engine.
//   While out_tready is low the current result holds; the queue keeps
//   accepting until it is full, then in_tready drops.
// ----------------------------------------------------------------------------
module float32_shortest_decimal_digits_top #(
  parameter int BIG_WORDS  = 5,
  parameter int MAX_DIGITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // float_bits [31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // negative [0], digit [4:1], dec_exponent [11:5], zero [15:12]
  output logic [1:0]  out_tuser,  // kind [1:0]
  output logic        out_tlast
);
  import f32sd_pkg::*;

  // front end to queue
  logic        fq_valid, fq_ready;
  f32sd_item_t fq_item;
  // queue to engine
  logic        qb_valid, qb_ready;
  f32sd_item_t qb_item;

  // classify incoming words
  f32sd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  // decouple classifier and engine
  f32sd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  // scale, generate and emit digits
  f32sd_back #(
    .BIG_WORDS  (BIG_WORDS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // special kinds are single-item runs
  a_special_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_DIGIT) |-> out_tlast)
    else $error("special result without last");

  // special kinds carry no digit and no exponent
  a_special_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_DIGIT) |-> (out_tdata[15:1] == 15'd0))
    else $error("special result with digit or exponent");

  // emitted digits are saturated
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DIGIT) |-> (out_tdata[4:1] <= DIGIT_NINE))
    else $error("digit above nine");

endmodule
